FILE: design/cpa_pkg.sv
// Shared types and constants for the contiguous page allocator.
// Transaction payloads, configuration set, page map entry layout and FSM states.
// No dependencies.
package cpa_pkg;

  localparam int CNT_W    = 11;
  localparam int PAGE_W   = 20;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Opcodes of a request transaction
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TOTAL    = 2'd0;
  localparam logic [1:0] REG_RESERVED = 2'd1;
  localparam logic [1:0] REG_BASE     = 2'd2;

  localparam logic [CNT_W-1:0]  TOTAL_RST    = 11'd1024;
  localparam logic [CNT_W-1:0]  RESERVED_RST = 11'd0;
  localparam logic [PAGE_W-1:0] BASE_RST     = 20'd0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RUN   = 2'd1,
    ST_BAD_FREE = 2'd2,
    ST_BAD_SIZE = 2'd3
  } cpa_status_t;

  typedef struct packed {
    logic              opcode;
    logic [CNT_W-1:0]  request_pages;
    logic [PAGE_W-1:0] page_number;
  } cpa_req_t;

  typedef struct packed {
    cpa_status_t       status;
    logic [PAGE_W-1:0] result_page;
  } cpa_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0]  total_pages;
    logic [CNT_W-1:0]  reserved_pages;
    logic [PAGE_W-1:0] base_page;
  } cpa_cfg_t;

  // One word of the page map
  typedef struct packed {
    logic             taken;
    logic             head;
    logic [CNT_W-1:0] length;
  } cpa_entry_t;

  localparam int ENT_W = $bits(cpa_entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FCHK,
    S_RELEASE,
    S_DONE
  } cpa_state_t;

endpackage

FILE: design/cpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cpa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/cpa_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on cpa_pkg for the register indexes, reset values and cpa_cfg_t.
module cpa_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [cpa_pkg::PADDR_W-1:0] paddr,
  input  logic [cpa_pkg::PDATA_W-1:0] pwdata,
  output logic [cpa_pkg::PDATA_W-1:0] prdata,
  output logic                     pready,
  output cpa_pkg::cpa_cfg_t        cfg
);
  import cpa_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_pages    <= TOTAL_RST;
      cfg.reserved_pages <= RESERVED_RST;
      cfg.base_page      <= BASE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TOTAL:    cfg.total_pages    <= pwdata[CNT_W-1:0];
        REG_RESERVED: cfg.reserved_pages <= pwdata[CNT_W-1:0];
        REG_BASE:     cfg.base_page      <= pwdata[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_TOTAL:    prdata = PDATA_W'(cfg.total_pages);
      REG_RESERVED: prdata = PDATA_W'(cfg.reserved_pages);
      REG_BASE:     prdata = PDATA_W'(cfg.base_page);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: design/cpa_ctrl.sv
// Allocation engine: page map RAM plus the sequencer that scans, marks and releases.
// Depends on cpa_pkg and cpa_ram.
module cpa_ctrl #(
  parameter int MAX_PAGES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  cpa_pkg::cpa_cfg_t cfg,
  input  logic              req_valid,
  output logic              req_stall,
  input  cpa_pkg::cpa_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output cpa_pkg::cpa_rsp_t rsp
);
  import cpa_pkg::*;

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
  localparam logic [CW-1:0]     MAX_C    = CW'(MAX_PAGES);
  localparam logic [IW-1:0]     LAST_IDX = IW'(MAX_PAGES - 1);
  localparam logic [PAGE_W-1:0] MAX_P    = PAGE_W'(MAX_PAGES);

  cpa_state_t        state, state_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     run, run_next;
  logic [CW-1:0]     start, start_next;
  logic [CW-1:0]     left, left_next;
  logic              dvalid, dvalid_next;
  logic [CNT_W-1:0]  req_len, req_len_next;
  cpa_status_t       res_status, res_status_next;
  logic [PAGE_W-1:0] res_page, res_page_next;
  logic              rsp_valid_next;
  logic              rsp_load;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  cpa_entry_t        ram_wdata;
  logic [ENT_W-1:0]  ram_rword;
  cpa_entry_t        rd;

  logic [CW-1:0]     lim, low, run_inc;
  logic [PAGE_W-1:0] free_idx;
  logic              found;

  cpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PAGES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rword)
  );

  assign rd = cpa_entry_t'(ram_rword);

  // Managed window: [low, lim)
  always_comb begin
    lim = (CW'(cfg.total_pages) > MAX_C) ? MAX_C : CW'(cfg.total_pages);
    low = (CW'(cfg.reserved_pages) > lim) ? lim : CW'(cfg.reserved_pages);
  end

  assign free_idx  = req.page_number - cfg.base_page;
  assign run_inc   = run + CW'(1);
  assign found     = dvalid && !rd.taken && (run_inc == CW'(req_len));
  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      dvalid    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      dvalid    <= dvalid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    run        <= run_next;
    start      <= start_next;
    left       <= left_next;
    req_len    <= req_len_next;
    res_status <= res_status_next;
    res_page   <= res_page_next;
    if (rsp_load) begin
      rsp.status      <= res_status;
      rsp.result_page <= res_page;
    end
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    run_next        = run;
    start_next      = start;
    left_next       = left;
    dvalid_next     = 1'b0;
    req_len_next    = req_len;
    res_status_next = res_status;
    res_page_next   = res_page;
    rsp_valid_next  = rsp_valid & rsp_stall;
    ram_we          = 1'b0;
    ram_waddr       = ptr[IW-1:0];
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = ptr[IW-1:0];

    case (state)
      // Sweep zeros through the page map after reset
      S_CLEAR: begin
        ram_we   = 1'b1;
        ptr_next = ptr + CW'(1);
        if (ptr[IW-1:0] == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end

      // Take a transaction and decode it
      S_IDLE: begin
        if (req_valid) begin
          res_page_next = '0;
          if (req.opcode == OP_ALLOC) begin
            req_len_next = req.request_pages;
            if (req.request_pages == '0) begin
              res_status_next = ST_BAD_SIZE;
              state_next      = S_DONE;
            end else begin
              ptr_next   = low;
              run_next   = '0;
              start_next = low;
              state_next = S_SCAN;
            end
          end else begin
            if (free_idx >= MAX_P) begin
              res_status_next = ST_BAD_FREE;
              state_next      = S_DONE;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = free_idx[IW-1:0];
              ptr_next   = CW'(free_idx);
              state_next = S_FCHK;
            end
          end
        end
      end

      // First-fit scan: one read issued and one word checked per cycle
      S_SCAN: begin
        if (found) begin
          ptr_next   = start;
          left_next  = CW'(req_len);
          state_next = S_MARK;
        end else begin
          if (dvalid) begin
            if (rd.taken) begin
              run_next   = '0;
              start_next = ptr;
            end else begin
              run_next = run_inc;
            end
          end
          if (ptr < lim) begin
            ram_re      = 1'b1;
            ptr_next    = ptr + CW'(1);
            dvalid_next = 1'b1;
          end else if (!dvalid) begin
            res_status_next = ST_NO_RUN;
            state_next      = S_DONE;
          end
        end
      end

      // Write the run: head on the first page, length on every page
      S_MARK: begin
        ram_we           = 1'b1;
        ram_wdata.taken  = 1'b1;
        ram_wdata.head   = (ptr == start);
        ram_wdata.length = req_len;
        ptr_next         = ptr + CW'(1);
        left_next        = left - CW'(1);
        if (left == CW'(1)) begin
          res_status_next = ST_OK;
          res_page_next   = cfg.base_page + PAGE_W'(start);
          state_next      = S_DONE;
        end
      end

      // Check that the addressed entry heads a block
      S_FCHK: begin
        if (!rd.head) begin
          res_status_next = ST_BAD_FREE;
          state_next      = S_DONE;
        end else if (rd.length == '0) begin
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end else begin
          left_next  = CW'(rd.length);
          state_next = S_RELEASE;
        end
      end

      // Clear the block, stopping at the end of the map
      S_RELEASE: begin
        ram_we    = 1'b1;
        ptr_next  = ptr + CW'(1);
        left_next = left - CW'(1);
        if (left == CW'(1) || ptr[IW-1:0] == LAST_IDX) begin
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (rsp_load) begin
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/contiguous_page_allocator_core.sv
// Top level of the first-fit contiguous page allocator.
// Depends on cpa_pkg, cpa_cfg and cpa_ctrl (which holds the cpa_ram page map).
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+----------------------------------
//  req      | in        | req_valid / req_stall       | opcode, request_pages, page_number
//  rsp      | out       | rsp_valid / rsp_stall       | status, result_page
//  apb      | in        | psel / penable / pwrite     | paddr, pwdata -> prdata
//
// One transaction at a time. Allocate: a first-fit scan through the single read port,
// then a write for each page of the run, then the hand-off of the result.
// Free: a read of the head entry, a write for each page released, then the hand-off.
// After reset the page map is swept to zero, with req_stall high.
// A held result in the output register does not block the next request; only the
// hand-off of the following result waits for rsp_stall to drop.
module contiguous_page_allocator_core #(
  parameter int MAX_PAGES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  cpa_pkg::cpa_req_t           req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output cpa_pkg::cpa_rsp_t           rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpa_pkg::PADDR_W-1:0] paddr,
  input  logic [cpa_pkg::PDATA_W-1:0] pwdata,
  output logic [cpa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import cpa_pkg::*;

  cpa_cfg_t cfg;

  cpa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpa_ctrl #(
    .MAX_PAGES (MAX_PAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Reset starts the clearing sweep, so no request may be taken just after it
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted during page map clear");

  // Only one transaction in flight: busy the cycle after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request accepted while busy");

  // Only a successful allocate carries a page number
  a_page_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.result_page == '0))
    else $error("non-zero result page on failed transaction");

endmodule
